// ----- rtl/slfp_pkg.sv -----
// ----------------------------------------------------------------------------
// slfp_pkg: shared types and constants for the syslog line field parser
// Parse phases, per-line parse state, result record and level lookup.
// ----------------------------------------------------------------------------
package slfp_pkg;

    localparam int MAX_LINE    = 4096;
    localparam int STAMP_CAP   = 31;
    localparam int SERVICE_CAP = 63;

    localparam int POS_W   = 13;  // holds 0..MAX_LINE
    localparam int STAMP_W = 5;
    localparam int SVC_W   = 6;
    localparam int LVL_W   = 3;

    typedef enum logic [3:0] {
        PH_FIRST  = 4'd0,
        PH_MONTH  = 4'd1,
        PH_DAYSP  = 4'd2,
        PH_DAY    = 4'd3,
        PH_TIME0  = 4'd4,
        PH_TIME   = 4'd5,
        PH_HOST   = 4'd6,
        PH_SVC    = 4'd7,
        PH_PID    = 4'd8,
        PH_OPTS   = 4'd9,
        PH_PRIOIN = 4'd10,
        PH_LVL    = 4'd11,
        PH_TAIL   = 4'd12,
        PH_TIDIN  = 4'd13,
        PH_MSG    = 4'd14,
        PH_NOMSG  = 4'd15
    } t_phase;

    localparam logic [LVL_W-1:0] LVL_NONE     = 3'd0;
    localparam logic [LVL_W-1:0] LVL_DEBUG    = 3'd1;
    localparam logic [LVL_W-1:0] LVL_INFO     = 3'd2;
    localparam logic [LVL_W-1:0] LVL_WARNING  = 3'd3;
    localparam logic [LVL_W-1:0] LVL_ERROR    = 3'd4;
    localparam logic [LVL_W-1:0] LVL_CRITICAL = 3'd5;

    // level names packed last byte lowest, as they are shifted in
    localparam logic [63:0] TXT_DEBUG    = 64'h0000_0044_4542_5547;
    localparam logic [63:0] TXT_INFO     = 64'h0000_0000_494E_464F;
    localparam logic [63:0] TXT_WARNING  = 64'h0057_4152_4E49_4E47;
    localparam logic [63:0] TXT_WARN     = 64'h0000_0000_5741_524E;
    localparam logic [63:0] TXT_ERROR    = 64'h0000_0045_5252_4F52;
    localparam logic [63:0] TXT_CRITICAL = 64'h4352_4954_4943_414C;

    typedef struct packed {
        t_phase              phase;
        logic [POS_W-1:0]    position;
        logic [1:0]          month_skip;
        logic [STAMP_W-1:0]  stamp_len;
        logic [POS_W-1:0]    svc_begin;
        logic [SVC_W-1:0]    svc_len;
        logic                svc_dot;
        logic [63:0]         level_chars;
        logic [3:0]          level_count;
        logic [POS_W-1:0]    msg_begin;
        logic [POS_W-1:0]    trim_end;
        logic [LVL_W-1:0]    level_found;
        logic                overflow;
    } t_state;

    typedef struct packed {
        logic [STAMP_W-1:0]  stamp_length;
        logic [POS_W-1:0]    service_start;
        logic [SVC_W-1:0]    service_length;
        logic [LVL_W-1:0]    level_code;
        logic [POS_W-1:0]    message_start;
        logic [POS_W-1:0]    message_length;
        logic                too_long;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:       PH_FIRST,
        position:    '0,
        month_skip:  '0,
        stamp_len:   '0,
        svc_begin:   '0,
        svc_len:     '0,
        svc_dot:     1'b0,
        level_chars: '0,
        level_count: '0,
        msg_begin:   '0,
        trim_end:    '0,
        level_found: '0,
        overflow:    1'b0
    };

    function automatic logic [STAMP_W-1:0] clamp_stamp(logic [POS_W-1:0] pos);
        return (pos < POS_W'(STAMP_CAP)) ? pos[STAMP_W-1:0] : STAMP_W'(STAMP_CAP);
    endfunction

    function automatic logic [LVL_W-1:0] match_level(logic [63:0] chars,
                                                     logic [3:0]  count);
        logic [LVL_W-1:0] code;
        code = LVL_NONE;
        if (count == 4'd5 && chars == TXT_DEBUG)    code = LVL_DEBUG;
        if (count == 4'd4 && chars == TXT_INFO)     code = LVL_INFO;
        if (count == 4'd7 && chars == TXT_WARNING)  code = LVL_WARNING;
        if (count == 4'd4 && chars == TXT_WARN)     code = LVL_WARNING;
        if (count == 4'd5 && chars == TXT_ERROR)    code = LVL_ERROR;
        if (count == 4'd8 && chars == TXT_CRITICAL) code = LVL_CRITICAL;
        return code;
    endfunction

endpackage

// ----- rtl/syslog_line_field_parser.sv -----
// ----------------------------------------------------------------------------
// syslog_line_field_parser: byte-stream syslog line parser
// Reports timestamp, service, level and message spans at each line end.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                 payload
//   -------  ---------  ------------------------  ------------------------------
//   in       sink       i_in_valid / o_in_ready   line_byte, byte_present,
//                                                 line_end
//   out      source     o_out_valid / i_out_ready stamp_length .. too_long
//
// One byte per cycle sustained. A transfer lands in the input register; as
// the byte moves on, the per-byte step and the end-of-line resolution run in
// one pass and, on a line end, load the result register. o_out_valid rises
// when the byte that ends the line moves on. Only a line end waits on a full
// result register; other bytes keep flowing while a result is held. Synchronous
// active-low reset clears the line state and both valid flags.
//
module syslog_line_field_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_line_byte,
    input  logic        i_byte_present,
    input  logic        i_line_end,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [4:0]  o_stamp_length,
    output logic [12:0] o_service_start,
    output logic [5:0]  o_service_length,
    output logic [2:0]  o_level_code,
    output logic [12:0] o_message_start,
    output logic [12:0] o_message_length,
    output logic        o_too_long
);
    import slfp_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_present;
    logic       r_in_last;

    // per-line parse state
    t_state     r_state;
    t_state     n_state;

    // result register
    logic       r_out_valid;
    t_result    r_out;
    t_result    n_out;

    logic       adv;

    // a held byte moves on unless it closes a line and the result slot is busy
    assign adv        = r_in_valid && (!r_in_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    slfp_step u_step (
        .i_state   (r_state),
        .i_byte    (r_in_byte),
        .i_present (r_in_present),
        .o_state   (n_state)
    );

    slfp_finish u_finish (
        .i_state  (n_state),
        .o_result (n_out)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (o_in_ready) r_in_valid <= i_in_valid;
            if (adv) begin
                // a line end starts the next line from scratch
                r_state <= r_in_last ? STATE_RESET : n_state;
            end
            if (adv && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte    <= i_line_byte;
            r_in_present <= i_byte_present;
            r_in_last    <= i_line_end;
        end
        if (adv && r_in_last) r_out <= n_out;
    end

    assign o_out_valid      = r_out_valid;
    assign o_stamp_length   = r_out.stamp_length;
    assign o_service_start  = r_out.service_start;
    assign o_service_length = r_out.service_length;
    assign o_level_code     = r_out.level_code;
    assign o_message_start  = r_out.message_start;
    assign o_message_length = r_out.message_length;
    assign o_too_long       = r_out.too_long;

endmodule

// ----- rtl/slfp_step.sv -----
// ----------------------------------------------------------------------------
// slfp_step: per-byte parse state update
// Advances the line state by one input byte; drops bytes past the line limit.
// ----------------------------------------------------------------------------
module slfp_step (
    input  slfp_pkg::t_state i_state,
    input  logic [7:0]       i_byte,
    input  logic             i_present,
    output slfp_pkg::t_state o_state
);
    import slfp_pkg::*;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;

    logic             is_digit;
    logic             is_space_like;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] pos_inc;
    logic [LVL_W-1:0] lvl_hit;

    // optional-prefix chain (':' then ' ' then <prio> then '[')
    logic [1:0]       op_ms_in;
    logic [1:0]       op_k;
    logic             op_done;
    t_phase           op_phase;
    logic [1:0]       op_ms;
    logic             op_lvl_clear;

    // level tail chain ((tid) then spaces)
    t_phase           tl_phase;

    assign is_digit      = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign is_space_like = (i_byte == CH_LF) || (i_byte == CH_CR) ||
                           (i_byte == CH_SPACE) || (i_byte == CH_TAB);
    assign pos     = i_state.position;
    assign pos_inc = pos + 1'b1;
    assign lvl_hit = match_level(i_state.level_chars, i_state.level_count);

    // the service end re-enters this chain at its first step with the same byte
    assign op_ms_in = (i_state.phase == PH_SVC) ? 2'd0 : i_state.month_skip;

    always_comb begin
        op_k         = op_ms_in;
        op_done      = 1'b0;
        op_phase     = PH_OPTS;
        op_ms        = op_ms_in;
        op_lvl_clear = 1'b0;
        if (op_k == 2'd0) begin
            if (i_byte == CH_COLON) begin
                op_ms   = 2'd1;
                op_done = 1'b1;
            end else begin
                op_k = 2'd1;
            end
        end
        if (!op_done && op_k == 2'd1) begin
            if (i_byte == CH_SPACE) begin
                op_ms   = 2'd2;
                op_done = 1'b1;
            end else begin
                op_k = 2'd2;
            end
        end
        if (!op_done && op_k == 2'd2) begin
            if (i_byte == CH_LT) begin
                op_ms    = 2'd3;
                op_phase = PH_PRIOIN;
                op_done  = 1'b1;
            end
        end
        if (!op_done) begin
            op_ms = 2'd3;
            if (i_byte == CH_LBRK) begin
                op_phase     = PH_LVL;
                op_lvl_clear = 1'b1;
            end else begin
                op_phase = PH_MSG;
            end
        end
    end

    always_comb begin
        if (i_state.month_skip == 2'd0 && i_byte == CH_LPAREN) begin
            tl_phase = PH_TIDIN;
        end else if (i_byte != CH_SPACE) begin
            tl_phase = PH_MSG;
        end else begin
            tl_phase = PH_TAIL;
        end
    end

    always_comb begin
        o_state = i_state;
        if (i_present) begin
            if (pos >= POS_W'(MAX_LINE)) begin
                o_state.overflow = 1'b1;
            end else begin
                o_state.position = pos_inc;
                if (!is_space_like) o_state.trim_end = pos_inc;
                unique case (i_state.phase)
                    PH_FIRST: begin
                        if (i_byte >= CH_UP_A && i_byte <= CH_UP_Z) begin
                            o_state.phase      = PH_MONTH;
                            o_state.month_skip = 2'd0;
                        end else begin
                            o_state.stamp_len = '0;
                            o_state.msg_begin = '0;
                            o_state.phase     = PH_MSG;
                        end
                    end
                    PH_MONTH: begin
                        if (i_state.month_skip >= 2'd1) begin
                            o_state.month_skip = 2'd0;
                            o_state.phase      = PH_DAYSP;
                        end else begin
                            o_state.month_skip = i_state.month_skip + 2'd1;
                        end
                    end
                    PH_DAYSP: begin
                        if (i_byte == CH_SPACE) begin
                            o_state.phase = PH_DAYSP;
                        end else if (is_digit) begin
                            o_state.phase = PH_DAY;
                        end else begin
                            o_state.stamp_len = '0;
                            o_state.msg_begin = '0;
                            o_state.phase     = PH_MSG;
                        end
                    end
                    PH_DAY: begin
                        if (is_digit) begin
                            o_state.phase = PH_DAY;
                        end else if (i_byte == CH_SPACE) begin
                            o_state.phase = PH_TIME0;
                        end else begin
                            o_state.stamp_len = '0;
                            o_state.msg_begin = '0;
                            o_state.phase     = PH_MSG;
                        end
                    end
                    PH_TIME0: begin
                        if (is_digit) begin
                            o_state.phase = PH_TIME;
                        end else begin
                            o_state.stamp_len = '0;
                            o_state.msg_begin = '0;
                            o_state.phase     = PH_MSG;
                        end
                    end
                    PH_TIME: begin
                        if (!(is_digit || i_byte == CH_COLON || i_byte == CH_DOT)) begin
                            o_state.stamp_len = clamp_stamp(pos);
                            o_state.phase = (i_byte == CH_SPACE) ? PH_HOST : PH_NOMSG;
                        end
                    end
                    PH_HOST: begin
                        if (i_byte == CH_SPACE) begin
                            o_state.svc_begin = pos_inc;
                            o_state.svc_len   = '0;
                            o_state.svc_dot   = 1'b0;
                            o_state.phase     = PH_SVC;
                        end
                    end
                    PH_SVC: begin
                        if (i_byte == CH_LBRK) begin
                            o_state.phase = PH_PID;
                        end else if (i_byte == CH_COLON || i_byte == CH_SPACE) begin
                            o_state.phase      = op_phase;
                            o_state.month_skip = op_ms;
                        end else if (i_byte == CH_DOT) begin
                            o_state.svc_dot = 1'b1;
                        end else if (!i_state.svc_dot &&
                                     i_state.svc_len < SVC_W'(SERVICE_CAP)) begin
                            o_state.svc_len = i_state.svc_len + 1'b1;
                        end
                    end
                    PH_PID: begin
                        if (i_byte == CH_RBRK) begin
                            o_state.phase      = PH_OPTS;
                            o_state.month_skip = 2'd0;
                        end
                    end
                    PH_OPTS: begin
                        o_state.phase      = op_phase;
                        o_state.month_skip = op_ms;
                        if (op_lvl_clear) begin
                            o_state.level_chars = '0;
                            o_state.level_count = '0;
                        end
                        if (op_phase == PH_MSG) o_state.msg_begin = pos;
                    end
                    PH_PRIOIN: begin
                        if (i_byte == CH_GT) begin
                            o_state.phase      = PH_OPTS;
                            o_state.month_skip = 2'd3;
                        end
                    end
                    PH_LVL: begin
                        if (i_byte == CH_RBRK) begin
                            o_state.level_found = lvl_hit;
                            if (lvl_hit != LVL_NONE) begin
                                o_state.phase      = PH_TAIL;
                                o_state.month_skip = 2'd0;
                            end else begin
                                o_state.msg_begin = pos_inc;
                                o_state.phase     = PH_MSG;
                            end
                        end else if (i_state.level_count < 4'd8) begin
                            o_state.level_chars = {i_state.level_chars[55:0], i_byte};
                            o_state.level_count = i_state.level_count + 4'd1;
                        end else begin
                            o_state.level_count = 4'd9;
                        end
                    end
                    PH_TAIL: begin
                        o_state.month_skip = 2'd1;
                        o_state.phase      = tl_phase;
                        if (tl_phase == PH_MSG) o_state.msg_begin = pos;
                    end
                    PH_TIDIN: begin
                        if (i_byte == CH_RPAREN) begin
                            o_state.phase      = PH_TAIL;
                            o_state.month_skip = 2'd1;
                        end
                    end
                    PH_MSG, PH_NOMSG: begin
                        o_state.phase = i_state.phase;
                    end
                endcase
            end
        end
    end

endmodule

// ----- rtl/slfp_finish.sv -----
// ----------------------------------------------------------------------------
// slfp_finish: end-of-line resolution
// Closes whatever phase the line stopped in and forms the result record.
// ----------------------------------------------------------------------------
module slfp_finish (
    input  slfp_pkg::t_state  i_state,
    output slfp_pkg::t_result o_result
);
    import slfp_pkg::*;

    logic [POS_W-1:0]   e;
    t_phase             f_phase;
    logic [POS_W-1:0]   f_msg_begin;
    logic [STAMP_W-1:0] f_stamp;
    logic [LVL_W-1:0]   f_level;

    assign e = i_state.position;

    always_comb begin
        f_phase     = i_state.phase;
        f_msg_begin = i_state.msg_begin;
        f_stamp     = i_state.stamp_len;
        f_level     = i_state.level_found;
        unique case (i_state.phase)
            PH_FIRST: begin
                f_msg_begin = '0;
                f_phase     = PH_MSG;
            end
            PH_MONTH, PH_DAYSP, PH_DAY, PH_TIME0: begin
                f_stamp     = '0;
                f_msg_begin = '0;
                f_phase     = PH_MSG;
            end
            PH_TIME: begin
                f_stamp = clamp_stamp(e);
                f_phase = PH_NOMSG;
            end
            PH_HOST: begin
                f_phase = PH_NOMSG;
            end
            PH_LVL: begin
                f_level     = match_level(i_state.level_chars, i_state.level_count);
                f_msg_begin = e;
                f_phase     = PH_MSG;
            end
            PH_MSG, PH_NOMSG: begin
                f_phase = i_state.phase;
            end
            PH_SVC, PH_PID, PH_OPTS, PH_PRIOIN, PH_TAIL, PH_TIDIN: begin
                f_msg_begin = e;
                f_phase     = PH_MSG;
            end
        endcase
    end

    always_comb begin
        o_result.stamp_length   = f_stamp;
        o_result.service_start  = i_state.svc_begin;
        o_result.service_length = i_state.svc_len;
        o_result.level_code     = f_level;
        o_result.too_long       = i_state.overflow;
        if (f_phase == PH_NOMSG) begin
            o_result.message_start  = '0;
            o_result.message_length = '0;
        end else begin
            o_result.message_start  = f_msg_begin;
            o_result.message_length = (i_state.trim_end > f_msg_begin) ?
                                      (i_state.trim_end - f_msg_begin) : '0;
        end
    end

endmodule
